// ===== hdl/sst_pkg.sv =====
// Shared types and codes for the sorted set table.
package sst_pkg;

   // field widths of the transfer payloads
   localparam int MODE_W   = 3;
   localparam int IN_KEY_W = 32;
   localparam int STATUS_W = 3;
   localparam int ELEM_W   = 32;
   localparam int POS_W    = 10;
   localparam int COUNT_W  = 11;

   // readout tree: cells are grouped by 32
   localparam int GRP_BITS = 5;
   localparam int GROUP    = 1 << GRP_BITS;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_SORTED_MODE = 1'b0;

   // operations
   localparam logic [MODE_W-1:0] OP_INSERT = 3'd0;
   localparam logic [MODE_W-1:0] OP_SEARCH = 3'd1;
   localparam logic [MODE_W-1:0] OP_REMOVE = 3'd2;
   localparam logic [MODE_W-1:0] OP_POP    = 3'd3;
   localparam logic [MODE_W-1:0] OP_SHIFT  = 3'd4;
   localparam logic [MODE_W-1:0] OP_PEEK   = 3'd5;
   localparam logic [MODE_W-1:0] OP_CLEAR  = 3'd6;

   // result status
   localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_PRESENT     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL        = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_ALLOWED = 3'd4;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INS,
      CELL_DEL
   } cell_op_type;

   typedef struct packed {
      logic lt;
      logic eq;
   } cell_flags_type;

   typedef struct packed {
      logic lt;
      logic eq;
      logic any;
   } tree_flags_type;

endpackage

// ===== hdl/sst_if.sv =====
// Request and response channel interfaces of the sorted set table.
interface sst_req_if;
   import sst_pkg::*;
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [IN_KEY_W-1:0] key;

   modport source (output valid, output mode, output key, input ready);
   modport sink   (input valid, input mode, input key, output ready);
endinterface

interface sst_rsp_if;
   import sst_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ELEM_W-1:0]   element;
   logic [POS_W-1:0]    position;
   logic [COUNT_W-1:0]  entry_count;

   modport source (output valid, output status, output element, output position,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input element, input position,
                   input entry_count, output ready);
endinterface

// ===== hdl/sst_cell.sv =====
// One storage cell of the key chain: holds a key, shifts with its neighbors.
module sst_cell #(
   parameter int KEY_BITS = 32,
   parameter int CAPACITY = 1024,
   parameter int INDEX    = 0
) (
   input  logic                           clock,
   input  sst_pkg::cell_op_type           cmd_op,
   input  logic [$clog2(CAPACITY)-1:0]    cmd_pos,
   input  logic [KEY_BITS-1:0]            arg_key,
   input  logic [$clog2(CAPACITY+1)-1:0]  fill,
   input  logic [KEY_BITS-1:0]            left_key,
   input  logic [KEY_BITS-1:0]            right_key,
   output logic [KEY_BITS-1:0]            key,
   output sst_pkg::cell_flags_type        flags
);
   import sst_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY+1);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
   localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

   logic [KEY_BITS-1:0] key_ff;
   logic [KEY_BITS-1:0] key_in;
   logic                valid;

   assign valid    = MY_CNT < fill;
   assign flags.lt = valid && (key_ff < arg_key);
   assign flags.eq = valid && (key_ff == arg_key);
   assign key      = key_ff;

   always_comb begin
      key_in = key_ff;
      case (cmd_op)
         CELL_INS: begin
            if (MY_IDX > cmd_pos) begin
               key_in = left_key;
            end else if (MY_IDX == cmd_pos) begin
               key_in = arg_key;
            end
         end
         CELL_DEL: begin
            if (MY_IDX >= cmd_pos) begin
               key_in = right_key;
            end
         end
         default: key_in = key_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

// ===== hdl/sst_tree.sv =====
// Two-stage registered readout of the cell chain: probed entry and first match.
module sst_tree #(
   parameter int KEY_BITS = 32,
   parameter int CAPACITY = 1024
) (
   input  logic                        clock,
   input  sst_pkg::cell_flags_type     cell_flags [CAPACITY],
   input  logic [KEY_BITS-1:0]         cell_keys  [CAPACITY],
   input  logic [$clog2(CAPACITY)-1:0] probe,
   output sst_pkg::tree_flags_type     rd_flags,
   output logic [KEY_BITS-1:0]         rd_key,
   output logic [$clog2(CAPACITY)-1:0] first_idx
);
   import sst_pkg::*;

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int NGRP   = (CAPACITY + GROUP - 1) / GROUP;
   localparam int GSEL_W = (NGRP > 1) ? $clog2(NGRP) : 1;
   localparam int PRB_W  = GSEL_W + GRP_BITS;

   cell_flags_type      pad_flags [NGRP*GROUP];
   logic [KEY_BITS-1:0] pad_keys  [NGRP*GROUP];
   logic [PRB_W-1:0]    probe_w;

   // stage 1: one result per group
   logic                grp_lt_in    [NGRP];
   logic                grp_eq_in    [NGRP];
   logic                grp_any_in   [NGRP];
   logic [GRP_BITS-1:0] grp_first_in [NGRP];
   logic [KEY_BITS-1:0] grp_key_in   [NGRP];
   logic                grp_lt_ff    [NGRP];
   logic                grp_eq_ff    [NGRP];
   logic                grp_any_ff   [NGRP];
   logic [GRP_BITS-1:0] grp_first_ff [NGRP];
   logic [KEY_BITS-1:0] grp_key_ff   [NGRP];
   logic [GSEL_W-1:0]   probe_hi_ff;

   // stage 2
   tree_flags_type      rd_flags_in;
   tree_flags_type      rd_flags_ff;
   logic [KEY_BITS-1:0] rd_key_in;
   logic [KEY_BITS-1:0] rd_key_ff;
   logic [PRB_W-1:0]    first_w;
   logic [IDX_W-1:0]    first_idx_ff;

   assign probe_w = PRB_W'(probe);

   for (genvar i = 0; i < NGRP*GROUP; i++) begin : g_pad
      if (i < CAPACITY) begin : g_real
         assign pad_flags[i] = cell_flags[i];
         assign pad_keys[i]  = cell_keys[i];
      end else begin : g_fill
         assign pad_flags[i] = '0;
         assign pad_keys[i]  = '0;
      end
   end

   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_lt_in[g]    = pad_flags[g*GROUP + int'(probe_w[GRP_BITS-1:0])].lt;
         grp_eq_in[g]    = pad_flags[g*GROUP + int'(probe_w[GRP_BITS-1:0])].eq;
         grp_key_in[g]   = pad_keys[g*GROUP + int'(probe_w[GRP_BITS-1:0])];
         grp_any_in[g]   = 1'b0;
         grp_first_in[g] = '0;
         // lowest matching entry wins
         for (int j = GROUP-1; j >= 0; j--) begin
            if (pad_flags[g*GROUP + j].eq) begin
               grp_any_in[g]   = 1'b1;
               grp_first_in[g] = GRP_BITS'(j);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < NGRP; g++) begin
         grp_lt_ff[g]    <= grp_lt_in[g];
         grp_eq_ff[g]    <= grp_eq_in[g];
         grp_any_ff[g]   <= grp_any_in[g];
         grp_first_ff[g] <= grp_first_in[g];
         grp_key_ff[g]   <= grp_key_in[g];
      end
      probe_hi_ff <= probe_w[PRB_W-1:GRP_BITS];
   end

   always_comb begin
      rd_flags_in.lt  = grp_lt_ff[probe_hi_ff];
      rd_flags_in.eq  = grp_eq_ff[probe_hi_ff];
      rd_flags_in.any = 1'b0;
      rd_key_in       = grp_key_ff[probe_hi_ff];
      first_w         = '0;
      for (int g = NGRP-1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            rd_flags_in.any = 1'b1;
            first_w         = {GSEL_W'(g), grp_first_ff[g]};
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_flags_ff  <= rd_flags_in;
      rd_key_ff    <= rd_key_in;
      first_idx_ff <= first_w[IDX_W-1:0];
   end

   assign rd_flags  = rd_flags_ff;
   assign rd_key    = rd_key_ff;
   assign first_idx = first_idx_ff;

endmodule

// ===== hdl/sorted_set_table.sv =====
// Sorted set table: bounded key set held in a shifting chain of cells.
// Clear and refused ops go straight to the result; unsorted insert appends; peek, pop,
//   shift and unsorted search read through the readout tree; sorted insert/search/remove
//   bisect, each step a probe through the readout tree (at most ceil(log2(n+1)) steps),
//   then probe the bound for an equal key unless it lies past the last entry.
// One operation is in flight at a time; a new request is taken while the last
//   response still waits. Reset clears the entry count and sets sorted mode;
//   key storage is not cleared and needs no sweep.
module sorted_set_table #(
   parameter int CAPACITY = 1024,
   parameter int KEY_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   sst_req_if.sink                           req_ch,
   sst_rsp_if.source                         rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [sst_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [sst_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [sst_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import sst_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY+1);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_BS_STEP  = 4'd1;
   localparam logic [3:0] S_WAIT_A   = 4'd2;
   localparam logic [3:0] S_WAIT_B   = 4'd3;
   localparam logic [3:0] S_BS_USE   = 4'd4;
   localparam logic [3:0] S_HIT_USE  = 4'd5;
   localparam logic [3:0] S_SCAN_USE = 4'd6;
   localparam logic [3:0] S_READ_USE = 4'd7;
   localparam logic [3:0] S_DECIDE   = 4'd8;
   localparam logic [3:0] S_RESULT   = 4'd9;

   logic [3:0]          state_ff, state_in;
   logic [3:0]          ret_ff, ret_in;
   logic [MODE_W-1:0]   op_ff, op_in;
   logic [KEY_BITS-1:0] k_ff, k_in;
   logic [CNT_W-1:0]    lo_ff, lo_in;
   logic [CNT_W-1:0]    hi_ff, hi_in;
   logic [IDX_W-1:0]    mid_ff, mid_in;
   logic [IDX_W-1:0]    probe_ff, probe_in;
   logic                hit_ff, hit_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic                sorted_mode_ff, sorted_mode_in;

   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [KEY_BITS-1:0] res_elem_ff, res_elem_in;
   logic [IDX_W-1:0]    res_pos_ff, res_pos_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ELEM_W-1:0]   rsp_element_ff, rsp_element_in;
   logic [POS_W-1:0]    rsp_position_ff, rsp_position_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic [63:0]         req_key_wide;
   logic [KEY_BITS-1:0] req_key;
   logic [63:0]         elem_wide;
   logic [31:0]         pos_wide;
   logic [31:0]         count_wide;
   logic [CNT_W-1:0]    mid_full;
   logic                csr_write;

   cell_op_type         cmd_op;
   logic [IDX_W-1:0]    cmd_pos;

   logic [KEY_BITS-1:0] cell_key   [CAPACITY];
   logic [KEY_BITS-1:0] left_key   [CAPACITY];
   logic [KEY_BITS-1:0] right_key  [CAPACITY];
   cell_flags_type      cell_flags [CAPACITY];

   tree_flags_type      rd_flags;
   logic [KEY_BITS-1:0] rd_key;
   logic [IDX_W-1:0]    first_idx;

   // ---------------- cell chain ----------------
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign left_key[i] = '0;
      end else begin : g_link_l
         assign left_key[i] = cell_key[i-1];
      end
      if (i == CAPACITY-1) begin : g_tail
         assign right_key[i] = '0;
      end else begin : g_link_r
         assign right_key[i] = cell_key[i+1];
      end

      sst_cell #(
         .KEY_BITS (KEY_BITS),
         .CAPACITY (CAPACITY),
         .INDEX    (i)
      ) u_cell (
         .clock     (clock),
         .cmd_op    (cmd_op),
         .cmd_pos   (cmd_pos),
         .arg_key   (k_ff),
         .fill      (fill_ff),
         .left_key  (left_key[i]),
         .right_key (right_key[i]),
         .key       (cell_key[i]),
         .flags     (cell_flags[i])
      );
   end

   sst_tree #(
      .KEY_BITS (KEY_BITS),
      .CAPACITY (CAPACITY)
   ) u_tree (
      .clock      (clock),
      .cell_flags (cell_flags),
      .cell_keys  (cell_key),
      .probe      (probe_ff),
      .rd_flags   (rd_flags),
      .rd_key     (rd_key),
      .first_idx  (first_idx)
   );

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      sorted_mode_in = sorted_mode_ff;
      if (csr_write && (csr_paddr[2] == REG_SORTED_MODE)) begin
         sorted_mode_in = csr_pwdata[0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_SORTED_MODE)
                       ? CSR_DATA_W'(sorted_mode_ff) : '0;

   // ---------------- sequencer ----------------
   assign req_key_wide = 64'(req_ch.key);
   assign req_key      = req_key_wide[KEY_BITS-1:0];
   assign mid_full     = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign req_ch.ready = (state_ff == S_IDLE);

   assign elem_wide  = 64'(res_elem_ff);
   assign pos_wide   = 32'(res_pos_ff);
   assign count_wide = 32'(fill_ff);

   always_comb begin
      state_in        = state_ff;
      ret_in          = ret_ff;
      op_in           = op_ff;
      k_in            = k_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      mid_in          = mid_ff;
      probe_in        = probe_ff;
      hit_in          = hit_ff;
      fill_in         = fill_ff;
      res_status_in   = res_status_ff;
      res_elem_in     = res_elem_ff;
      res_pos_in      = res_pos_ff;
      cmd_op          = CELL_HOLD;
      cmd_pos         = lo_ff[IDX_W-1:0];
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in   = rsp_status_ff;
      rsp_element_in  = rsp_element_ff;
      rsp_position_in = rsp_position_ff;
      rsp_count_in    = rsp_count_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in         = req_ch.mode;
               k_in          = req_key;
               lo_in         = '0;
               hi_in         = fill_ff;
               hit_in        = 1'b0;
               res_status_in = ST_OK;
               res_elem_in   = '0;
               res_pos_in    = '0;
               unique case (req_ch.mode) inside
                  OP_INSERT: begin
                     if (sorted_mode_ff) begin
                        state_in = S_BS_STEP;
                     end else begin
                        lo_in    = fill_ff;
                        state_in = S_DECIDE;
                     end
                  end
                  OP_SEARCH: begin
                     if (sorted_mode_ff) begin
                        state_in = S_BS_STEP;
                     end else begin
                        ret_in   = S_SCAN_USE;
                        state_in = S_WAIT_A;
                     end
                  end
                  OP_REMOVE: begin
                     if (sorted_mode_ff) begin
                        state_in = S_BS_STEP;
                     end else begin
                        res_status_in = ST_NOT_ALLOWED;
                        state_in      = S_RESULT;
                     end
                  end
                  OP_POP, OP_SHIFT, OP_PEEK: begin
                     if (fill_ff == '0) begin
                        res_status_in = ST_NOT_FOUND;
                        state_in      = S_RESULT;
                     end else begin
                        probe_in = (req_ch.mode == OP_POP)
                                   ? IDX_W'(fill_ff - CNT_W'(1)) : '0;
                        ret_in   = S_READ_USE;
                        state_in = S_WAIT_A;
                     end
                  end
                  OP_CLEAR: begin
                     fill_in  = '0;
                     state_in = S_RESULT;
                  end
                  default: begin
                     res_status_in = ST_NOT_ALLOWED;
                     state_in      = S_RESULT;
                  end
               endcase
            end
         end
         S_BS_STEP: begin
            if (lo_ff < hi_ff) begin
               mid_in   = IDX_W'(mid_full);
               probe_in = IDX_W'(mid_full);
               ret_in   = S_BS_USE;
               state_in = S_WAIT_A;
            end else if (lo_ff < fill_ff) begin
               // lower bound found, check for an equal key there
               probe_in = IDX_W'(lo_ff);
               ret_in   = S_HIT_USE;
               state_in = S_WAIT_A;
            end else begin
               hit_in   = 1'b0;
               state_in = S_DECIDE;
            end
         end
         S_WAIT_A: state_in = S_WAIT_B;
         S_WAIT_B: state_in = ret_ff;
         S_BS_USE: begin
            if (rd_flags.lt) begin
               lo_in = CNT_W'(mid_ff) + CNT_W'(1);
            end else begin
               hi_in = CNT_W'(mid_ff);
            end
            state_in = S_BS_STEP;
         end
         S_HIT_USE: begin
            hit_in   = rd_flags.eq;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            unique case (op_ff) inside
               OP_INSERT: begin
                  if (hit_ff) begin
                     res_status_in = ST_PRESENT;
                     res_elem_in   = k_ff;
                     res_pos_in    = IDX_W'(lo_ff);
                  end else if (fill_ff >= CNT_W'(CAPACITY)) begin
                     res_status_in = ST_FULL;
                     res_elem_in   = k_ff;
                  end else begin
                     cmd_op      = CELL_INS;
                     fill_in     = fill_ff + CNT_W'(1);
                     res_elem_in = k_ff;
                     res_pos_in  = IDX_W'(lo_ff);
                  end
               end
               OP_SEARCH: begin
                  if (hit_ff) begin
                     res_elem_in = k_ff;
                     res_pos_in  = IDX_W'(lo_ff);
                  end else begin
                     res_status_in = ST_NOT_FOUND;
                  end
               end
               OP_REMOVE: begin
                  if (hit_ff) begin
                     cmd_op      = CELL_DEL;
                     fill_in     = fill_ff - CNT_W'(1);
                     res_elem_in = k_ff;
                     res_pos_in  = IDX_W'(lo_ff);
                  end else begin
                     res_status_in = ST_NOT_FOUND;
                  end
               end
               default: res_status_in = ST_NOT_ALLOWED;
            endcase
            state_in = S_RESULT;
         end
         S_SCAN_USE: begin
            if (rd_flags.any) begin
               res_elem_in = k_ff;
               res_pos_in  = first_idx;
            end else begin
               res_status_in = ST_NOT_FOUND;
            end
            state_in = S_RESULT;
         end
         S_READ_USE: begin
            res_elem_in = rd_key;
            unique case (op_ff) inside
               OP_POP: begin
                  res_pos_in = IDX_W'(fill_ff - CNT_W'(1));
                  fill_in    = fill_ff - CNT_W'(1);
               end
               OP_SHIFT: begin
                  cmd_op  = CELL_DEL;
                  cmd_pos = '0;
                  fill_in = fill_ff - CNT_W'(1);
               end
               default: res_pos_in = '0;
            endcase
            state_in = S_RESULT;
         end
         S_RESULT: begin
            // response register is free or being drained this cycle
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = res_status_ff;
               rsp_element_in  = elem_wide[ELEM_W-1:0];
               rsp_position_in = pos_wide[POS_W-1:0];
               rsp_count_in    = count_wide[COUNT_W-1:0];
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         fill_ff        <= '0;
         sorted_mode_ff <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         fill_ff        <= fill_in;
         sorted_mode_ff <= sorted_mode_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff          <= ret_in;
      op_ff           <= op_in;
      k_ff            <= k_in;
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      mid_ff          <= mid_in;
      probe_ff        <= probe_in;
      hit_ff          <= hit_in;
      res_status_ff   <= res_status_in;
      res_elem_ff     <= res_elem_in;
      res_pos_ff      <= res_pos_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_element_ff  <= rsp_element_in;
      rsp_position_ff <= rsp_position_in;
      rsp_count_ff    <= rsp_count_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.element     = rsp_element_ff;
   assign rsp_ch.position    = rsp_position_ff;
   assign rsp_ch.entry_count = rsp_count_ff;

   // ---------------- checks ----------------
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (fill_ff != $past(fill_ff)) |->
         (fill_ff == $past(fill_ff) + CNT_W'(1) ||
          fill_ff == $past(fill_ff) - CNT_W'(1) ||
          fill_ff == '0))
      else $error("entry count moved by more than one");

   a_cmd_state: assert property (@(posedge clock) disable iff (reset)
      (cmd_op != CELL_HOLD) |-> (state_ff == S_DECIDE || state_ff == S_READ_USE))
      else $error("chain shift outside a commit state");

   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_RESULT))
      else $error("response raised without a finished operation");

endmodule

// ===== tb/sv/sorted_set_table_tb.sv =====
// Self-checking testbench for the sorted set table: directed and random operations.
module sorted_set_table_tb;
   import sst_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned TABLE_DEPTH     = 1024;
   localparam int unsigned WATCHDOG_LIMIT  = 4000;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   localparam int unsigned DRAIN_CYCLES    = 64;
   localparam int unsigned CSR_GAP_CYCLES  = 8;
   localparam int unsigned NO_HOLD         = 32'hFFFF_FFFF;

   localparam logic [MODE_W-1:0]     OP_UNDEFINED     = 3'd7;
   localparam logic [CSR_ADDR_W-1:0] SORTED_MODE_ADDR = CSR_ADDR_W'(4 * REG_SORTED_MODE);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ELEM_W-1:0]   element;
      logic [POS_W-1:0]    position;
      logic [COUNT_W-1:0]  entry_count;
   } reply_type;

   // Mirror of the key table; predicts the reply to every accepted request.
   class set_table_mirror;
      logic [ELEM_W-1:0] keys [TABLE_DEPTH];
      int unsigned       n_keys;
      bit                ordered;
      reply_type         pending_replies [$];
      int unsigned       errors;

      function new();
         n_keys  = 0;
         ordered = 1'b1;
         errors  = 0;
      endfunction

      function void set_ordered(bit value);
         ordered = value;
      endfunction

      function int unsigned outstanding();
         return pending_replies.size();
      endfunction

      function void flag_error(string what);
         errors++;
         if (errors <= 10) $display("%0t mismatch: %s", $realtime, what);
      endfunction

      // first index whose key is not below k; runs the same on unordered contents
      function int unsigned lower_bound(logic [ELEM_W-1:0] k, output bit hit);
         int unsigned lo, hi, mid;
         lo = 0;
         hi = n_keys;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (keys[mid] < k) lo = mid + 1;
            else hi = mid;
         end
         hit = (lo < n_keys) && (keys[lo] == k);
         return lo;
      endfunction

      function void drop_entry(int unsigned p);
         for (int unsigned i = p; i + 1 < n_keys; i++) keys[i] = keys[i + 1];
         n_keys--;
      endfunction

      function void note_request(logic [MODE_W-1:0] op, logic [IN_KEY_W-1:0] key);
         reply_type   r;
         int unsigned p;
         bit          hit;
         r   = '0;
         p   = 0;
         hit = 1'b0;
         case (op)
            OP_INSERT: begin
               if (ordered) p = lower_bound(key, hit);
               else p = n_keys;
               if (hit) begin
                  r.status   = ST_PRESENT;
                  r.element  = keys[p];
                  r.position = POS_W'(p);
               end else if (n_keys >= TABLE_DEPTH) begin
                  r.status  = ST_FULL;
                  r.element = key;
               end else begin
                  for (int unsigned i = n_keys; i > p; i--) keys[i] = keys[i - 1];
                  keys[p] = key;
                  n_keys++;
                  r.element  = key;
                  r.position = POS_W'(p);
               end
            end
            OP_SEARCH: begin
               if (ordered) begin
                  p = lower_bound(key, hit);
               end else begin
                  for (int unsigned i = 0; i < n_keys; i++) begin
                     if (!hit && keys[i] == key) begin
                        hit = 1'b1;
                        p   = i;
                     end
                  end
               end
               if (hit) begin
                  r.element  = keys[p];
                  r.position = POS_W'(p);
               end else begin
                  r.status = ST_NOT_FOUND;
               end
            end
            OP_REMOVE: begin
               if (!ordered) begin
                  r.status = ST_NOT_ALLOWED;
               end else begin
                  p = lower_bound(key, hit);
                  if (hit) begin
                     r.element  = keys[p];
                     r.position = POS_W'(p);
                     drop_entry(p);
                  end else begin
                     r.status = ST_NOT_FOUND;
                  end
               end
            end
            OP_POP: begin
               if (n_keys == 0) begin
                  r.status = ST_NOT_FOUND;
               end else begin
                  n_keys--;
                  r.element  = keys[n_keys];
                  r.position = POS_W'(n_keys);
               end
            end
            OP_SHIFT: begin
               if (n_keys == 0) begin
                  r.status = ST_NOT_FOUND;
               end else begin
                  r.element = keys[0];
                  drop_entry(0);
               end
            end
            OP_PEEK: begin
               if (n_keys == 0) r.status = ST_NOT_FOUND;
               else r.element = keys[0];
            end
            OP_CLEAR: begin
               n_keys = 0;
            end
            default: begin
               r.status = ST_NOT_ALLOWED;
            end
         endcase
         r.entry_count = COUNT_W'(n_keys);
         pending_replies.push_back(r);
      endfunction

      function void check_result(reply_type got);
         reply_type want;
         if (pending_replies.size() == 0) begin
            flag_error($sformatf("unexpected reply status=%0d element=%h position=%0d count=%0d",
                                 got.status, got.element, got.position, got.entry_count));
            return;
         end
         want = pending_replies.pop_front();
         if (got.status !== want.status || got.element !== want.element ||
             got.position !== want.position || got.entry_count !== want.entry_count)
            flag_error($sformatf({"expected status=%0d element=%h position=%0d count=%0d, ",
                                  "got status=%0d element=%h position=%0d count=%0d"},
                                 want.status, want.element, want.position, want.entry_count,
                                 got.status, got.element, got.position, got.entry_count));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   sst_req_if req_bus ();
   sst_rsp_if rsp_bus ();

   set_table_mirror book;

   int unsigned src_idle_pct  = 0;
   int unsigned sink_idle_pct = 0;
   int unsigned hold_asks     = 0;
   int unsigned stall_cycles  = 0;

   sorted_set_table #(
      .CAPACITY (TABLE_DEPTH),
      .KEY_BITS (32)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ends the run when no transfer happens for too long
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("sorted_set_table verification failed");
         $finish;
      end
   end

   // response side: random back-pressure plus an occasional long hold-off
   initial begin : response_sink
      reply_type   got;
      int unsigned hold_left;
      int unsigned hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.status      = rsp_bus.status;
            got.element     = rsp_bus.element;
            got.position    = rsp_bus.position;
            got.entry_count = rsp_bus.entry_count;
            book.check_result(got);
         end
         if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
         end
      end
   end

   task automatic send_op(input logic [MODE_W-1:0] op, input logic [IN_KEY_W-1:0] key);
      if ($urandom_range(99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < src_idle_pct);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode  <= op;
      req_bus.key   <= key;
      do @(posedge clock); while (!req_bus.ready);
      book.note_request(op, key);
   endtask

   // waits until the table is idle; reads the register back after the write
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      req_bus.valid <= 1'b0;
      while (book.outstanding() != 0) @(posedge clock);
      repeat (CSR_GAP_CYCLES) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      book.set_ordered(data[0]);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[0] !== data[0])
         book.flag_error($sformatf("register readback %h, wrote %h", csr_prdata, data));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic [MODE_W-1:0] pick_op();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 36) return OP_INSERT;
      if (r < 56) return OP_SEARCH;
      if (r < 70) return OP_REMOVE;
      if (r < 78) return OP_POP;
      if (r < 86) return OP_SHIFT;
      if (r < 94) return OP_PEEK;
      if (r < 97) return OP_CLEAR;
      return OP_UNDEFINED;
   endfunction

   // often keys already held, so hits, duplicates and removals are frequent
   function automatic logic [IN_KEY_W-1:0] pick_key();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 40 && book.n_keys > 0) return book.keys[$urandom_range(book.n_keys - 1)];
      if (r < 60) return IN_KEY_W'($urandom_range(31));
      if (r < 65) return '0;
      if (r < 70) return '1;
      return $urandom();
   endfunction

   task automatic run_random(input int unsigned n_items, input int unsigned hold_at);
      for (int unsigned i = 0; i < n_items; i++) begin
         if (i == hold_at) hold_asks++;
         send_op(pick_op(), pick_key());
      end
   endtask

   initial begin : stimulus
      book = new();
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.mode   <= '0;
      req_bus.key    <= '0;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed, ordered set: empty table, key extremes, duplicate, misses
      write_csr(SORTED_MODE_ADDR, 32'd1);
      send_op(OP_PEEK, 32'h0);
      send_op(OP_POP, 32'h0);
      send_op(OP_SHIFT, 32'h0);
      send_op(OP_SEARCH, 32'h5);
      send_op(OP_REMOVE, 32'h5);
      send_op(OP_INSERT, 32'hFFFF_FFFF);
      send_op(OP_INSERT, 32'h0);
      send_op(OP_INSERT, 32'h8000_0000);
      send_op(OP_INSERT, 32'h8000_0000);
      send_op(OP_SEARCH, 32'h0);
      send_op(OP_SEARCH, 32'h7FFF_FFFF);
      send_op(OP_REMOVE, 32'h8000_0000);
      send_op(OP_PEEK, 32'hFFFF_FFFF);
      send_op(OP_POP, 32'h0);
      send_op(OP_SHIFT, 32'h0);
      send_op(OP_UNDEFINED, 32'h1234_5678);
      send_op(OP_INSERT, 32'h5555_5555);
      send_op(OP_INSERT, 32'hAAAA_AAAA);
      send_op(OP_CLEAR, 32'hFFFF_FFFF);

      // directed, append vector: repeated key, remove refused
      write_csr(SORTED_MODE_ADDR, 32'd0);
      send_op(OP_INSERT, 32'h9);
      send_op(OP_INSERT, 32'h3);
      send_op(OP_INSERT, 32'h9);
      send_op(OP_SEARCH, 32'h9);
      send_op(OP_REMOVE, 32'h3);
      send_op(OP_POP, 32'h0);
      send_op(OP_CLEAR, 32'h0);

      src_idle_pct  = 17;
      sink_idle_pct = 50;
      write_csr(SORTED_MODE_ADDR, 32'd1);
      run_random(350, 150);

      src_idle_pct  = 50;
      sink_idle_pct = 17;
      write_csr(SORTED_MODE_ADDR, 32'd0);
      run_random(350, NO_HOLD);

      // contents left by the append phase are usually out of order here
      src_idle_pct  = 0;
      sink_idle_pct = 0;
      write_csr(SORTED_MODE_ADDR, 32'd1);
      run_random(250, NO_HOLD);

      // fill the table to capacity with ascending keys
      send_op(OP_CLEAR, $urandom());
      for (int i = 0; i < TABLE_DEPTH; i++) send_op(OP_INSERT, {10'(i), 22'($urandom())});
      send_op(OP_INSERT, 32'hFFFF_FFFF);
      send_op(OP_INSERT, book.keys[TABLE_DEPTH - 1]);
      send_op(OP_INSERT, book.keys[0]);
      send_op(OP_SEARCH, book.keys[TABLE_DEPTH - 1]);
      send_op(OP_PEEK, $urandom());
      write_csr(SORTED_MODE_ADDR, 32'd0);
      send_op(OP_INSERT, 32'h0);
      send_op(OP_SEARCH, book.keys[TABLE_DEPTH - 1]);
      send_op(OP_REMOVE, book.keys[3]);
      send_op(OP_POP, $urandom());
      send_op(OP_INSERT, 32'hFFFF_FFFF);
      write_csr(SORTED_MODE_ADDR, 32'd1);
      send_op(OP_SHIFT, $urandom());
      send_op(OP_REMOVE, book.keys[500]);
      send_op(OP_PEEK, $urandom());
      send_op(OP_CLEAR, $urandom());
      send_op(OP_PEEK, $urandom());

      req_bus.valid <= 1'b0;
      while (book.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (book.errors == 0)
         $display("sorted_set_table verification clean");
      else
         $display("sorted_set_table verification failed");
      $finish;
   end

endmodule
